// ===== sv/clp_pkg.sv =====
package clp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
    localparam int HEAD_DEPTH    = 7;
    localparam int HEAD_IDX_W    = $clog2(HEAD_DEPTH);

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;

    localparam logic [7:0] MAX_HOURS = 8'd23;
    localparam logic [7:0] MAX_MS    = 8'd59;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_TIME = 2'd1;
    localparam logic [1:0] CMD_MODE = 2'd2;
    localparam logic [1:0] CMD_FREQ = 2'd3;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       dfu_request;
        logic       reply_valid;
        logic       reply_ok;
        logic [1:0] command_kind;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       hour_mode_24;
        logic [5:0] frequency;
    } t_result;

    // two ASCII digits to a value, mod 256, no digit check
    function automatic logic [7:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] da;
        logic [7:0] db;
        da = a - CH_0;
        db = b - CH_0;
        return 8'(da * 8'd10 + db);
    endfunction

endpackage

// ===== sv/clp_if.sv =====
interface clp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clp_out_if;
    logic              valid;
    logic              ready;
    clp_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/clock_command_line_parser.sv =====
// Clock command line parser.
// i_rx carries one received byte per word; o_tx carries one result word per
// input word: the echoed byte, the '!' update request, and on a CR or LF that
// ends a non-empty line the ok/error reply with the parsed command fields.
// Commands: 't'HHMMSS set time, 'h'0/1 hour mode, 'f'DD frequency 1..59.
// The result word is registered and is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result word is not stalled; the
// parse of the seven stored head bytes and the length counter update are
// combinational, ahead of the result register.
// i_rx.ready is high while the result register is empty or being taken, so
// a stalled receiver holds the current result and i_rx stays stalled for as
// long as it does; bytes flow again in the cycle the result is taken.
// Reset (synchronous, active low) empties the result register and clears
// the line length; head bytes are only read after written for the line.
// Lines longer than the capacity are echoed but no longer counted.
module clock_command_line_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    clp_in_if.sink          i_rx,
    clp_out_if.source       o_tx
);

    logic [clp_pkg::LEN_W-1:0] r_len;
    logic [clp_pkg::LEN_W-1:0] n_len;
    logic [7:0]                r_head [clp_pkg::HEAD_DEPTH];
    logic                      n_head_we;
    logic                      r_out_valid;
    clp_pkg::t_result          r_out;
    clp_pkg::t_result          n_out;
    logic                      accept;
    logic [7:0]                c;
    logic [7:0]                hh;
    logic [7:0]                mm;
    logic [7:0]                ss;
    logic [7:0]                ff;

    assign i_rx.ready  = !r_out_valid || o_tx.ready;
    assign accept      = i_rx.valid && i_rx.ready;
    assign c           = i_rx.rx_byte;
    assign o_tx.valid  = r_out_valid;
    assign o_tx.data   = r_out;

    assign hh = clp_pkg::digit_pair(r_head[1], r_head[2]);
    assign mm = clp_pkg::digit_pair(r_head[3], r_head[4]);
    assign ss = clp_pkg::digit_pair(r_head[5], r_head[6]);
    assign ff = clp_pkg::digit_pair(r_head[1], r_head[2]);

    always_comb begin
        n_out           = '0;
        n_out.echo_byte = c;
        n_len           = r_len;
        n_head_we       = 1'b0;
        priority if (c == clp_pkg::CH_BANG) begin
            n_out.dfu_request = 1'b1;
        end else if (c == clp_pkg::CH_LF || c == clp_pkg::CH_CR) begin
            if (r_len != '0) begin
                n_out.reply_valid = 1'b1;
                n_len             = '0;
                priority if (r_head[0] == clp_pkg::CH_T
                             && r_len == clp_pkg::LEN_W'(7)) begin
                    if (hh <= clp_pkg::MAX_HOURS && mm <= clp_pkg::MAX_MS
                        && ss <= clp_pkg::MAX_MS) begin
                        n_out.reply_ok     = 1'b1;
                        n_out.command_kind = clp_pkg::CMD_TIME;
                        n_out.hours        = hh[4:0];
                        n_out.minutes      = mm[5:0];
                        n_out.seconds      = ss[5:0];
                    end
                end else if (r_head[0] == clp_pkg::CH_H
                             && r_len == clp_pkg::LEN_W'(2)) begin
                    if (r_head[1] == clp_pkg::CH_0 || r_head[1] == clp_pkg::CH_1) begin
                        n_out.reply_ok     = 1'b1;
                        n_out.command_kind = clp_pkg::CMD_MODE;
                        n_out.hour_mode_24 = (r_head[1] == clp_pkg::CH_1);
                    end
                end else if (r_head[0] == clp_pkg::CH_F
                             && r_len == clp_pkg::LEN_W'(3)) begin
                    if (ff != 8'd0 && ff <= clp_pkg::MAX_MS) begin
                        n_out.reply_ok     = 1'b1;
                        n_out.command_kind = clp_pkg::CMD_FREQ;
                        n_out.frequency    = ff[5:0];
                    end
                end else begin
                    n_out.reply_ok = 1'b0;
                end
            end
        end else begin
            if (r_len < clp_pkg::LEN_W'(clp_pkg::LINE_CAPACITY)) begin
                n_len     = r_len + clp_pkg::LEN_W'(1);
                n_head_we = (r_len < clp_pkg::LEN_W'(clp_pkg::HEAD_DEPTH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
        if (accept && n_head_we) begin
            r_head[r_len[clp_pkg::HEAD_IDX_W-1:0]] <= c;
        end
    end

endmodule

// ===== sv/clp_checker.sv =====
module clp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [7:0]       i_in_byte,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input clp_pkg::t_result i_out_data
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // every accepted byte shows up as the next result word, echoed
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid
            && i_out_data.echo_byte == $past(i_in_byte))
        else $error("accepted byte not echoed in next cycle");

    // ok reply only with a command and only on a line end
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.reply_ok |-> i_out_data.reply_valid
            && i_out_data.command_kind != clp_pkg::CMD_NONE
            && (i_out_data.echo_byte == clp_pkg::CH_LF
                || i_out_data.echo_byte == clp_pkg::CH_CR))
        else $error("ok reply without command on line end");

    // update request never carries a reply
    a_dfu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.dfu_request |-> !i_out_data.reply_valid
            && i_out_data.echo_byte == clp_pkg::CH_BANG)
        else $error("bad update request word");

endmodule

bind clock_command_line_parser clp_checker u_clp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_in_byte   (i_rx.rx_byte),
    .i_out_valid (o_tx.valid),
    .i_out_ready (o_tx.ready),
    .i_out_data  (o_tx.data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1150;
    localparam int N_DIR       = 25;
    localparam int PRINT_CAP   = 60;

    typedef struct {
        logic [7:0]       b;
        bit               fixed;
        clp_pkg::t_result want;
    } t_word_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    clp_in_if  rx_if ();
    clp_out_if tx_if ();

    clock_command_line_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_tx    (tx_if)
    );

    t_word_item       word_q[$];
    t_word_item       dir_tab[N_DIR];
    clp_pkg::t_result pending_words[$];

    int send_idx  = 0;
    int got_cnt   = 0;
    int err_cnt   = 0;
    int cyc       = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit rx_took   = 1'b0;

    // parser state mirror
    int         ln_len;
    logic [7:0] ln_head[clp_pkg::HEAD_DEPTH];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] pair_value(logic [7:0] a, logic [7:0] b);
        int v;
        v = (int'(a) - 48) * 10 + (int'(b) - 48);
        return v[7:0];
    endfunction

    function automatic clp_pkg::t_result predict_reply(logic [7:0] c);
        clp_pkg::t_result r;
        logic [7:0]       hh;
        logic [7:0]       mm;
        logic [7:0]       ss;
        logic [7:0]       ff;
        r = '0;
        r.echo_byte = c;
        if (c == clp_pkg::CH_BANG) begin
            r.dfu_request = 1'b1;
        end else if (c == clp_pkg::CH_LF || c == clp_pkg::CH_CR) begin
            if (ln_len != 0) begin
                r.reply_valid = 1'b1;
                if (ln_head[0] == clp_pkg::CH_T && ln_len == 7) begin
                    hh = pair_value(ln_head[1], ln_head[2]);
                    mm = pair_value(ln_head[3], ln_head[4]);
                    ss = pair_value(ln_head[5], ln_head[6]);
                    if (hh <= clp_pkg::MAX_HOURS && mm <= clp_pkg::MAX_MS
                        && ss <= clp_pkg::MAX_MS) begin
                        r.reply_ok     = 1'b1;
                        r.command_kind = clp_pkg::CMD_TIME;
                        r.hours        = hh[4:0];
                        r.minutes      = mm[5:0];
                        r.seconds      = ss[5:0];
                    end
                end else if (ln_head[0] == clp_pkg::CH_H && ln_len == 2) begin
                    if (ln_head[1] == clp_pkg::CH_0 || ln_head[1] == clp_pkg::CH_1) begin
                        r.reply_ok     = 1'b1;
                        r.command_kind = clp_pkg::CMD_MODE;
                        r.hour_mode_24 = (ln_head[1] == clp_pkg::CH_1);
                    end
                end else if (ln_head[0] == clp_pkg::CH_F && ln_len == 3) begin
                    ff = pair_value(ln_head[1], ln_head[2]);
                    if (ff != 8'd0 && ff <= clp_pkg::MAX_MS) begin
                        r.reply_ok     = 1'b1;
                        r.command_kind = clp_pkg::CMD_FREQ;
                        r.frequency    = ff[5:0];
                    end
                end
                ln_len = 0;
            end
        end else if (ln_len < clp_pkg::LINE_CAPACITY) begin
            if (ln_len < clp_pkg::HEAD_DEPTH) ln_head[ln_len] = c;
            ln_len++;
        end
        return r;
    endfunction

    function automatic clp_pkg::t_result want_of(logic [7:0] e, bit dfu, bit rv);
        clp_pkg::t_result r;
        r = '0;
        r.echo_byte   = e;
        r.dfu_request = dfu;
        r.reply_valid = rv;
        return r;
    endfunction

    task automatic report(string msg);
        if (err_cnt < PRINT_CAP) $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    task automatic chk(string name, int n, int got, int want);
        if (got != want) report($sformatf("word %0d %s got %0h want %0h", n, name, got, want));
    endtask

    task automatic compare_word(clp_pkg::t_result got, clp_pkg::t_result want, int n);
        chk("echo_byte",    n, int'(got.echo_byte),    int'(want.echo_byte));
        chk("dfu_request",  n, int'(got.dfu_request),  int'(want.dfu_request));
        chk("reply_valid",  n, int'(got.reply_valid),  int'(want.reply_valid));
        chk("reply_ok",     n, int'(got.reply_ok),     int'(want.reply_ok));
        chk("command_kind", n, int'(got.command_kind), int'(want.command_kind));
        chk("hours",        n, int'(got.hours),        int'(want.hours));
        chk("minutes",      n, int'(got.minutes),      int'(want.minutes));
        chk("seconds",      n, int'(got.seconds),      int'(want.seconds));
        chk("hour_mode_24", n, int'(got.hour_mode_24), int'(want.hour_mode_24));
        chk("frequency",    n, int'(got.frequency),    int'(want.frequency));
    endtask

    task automatic push_byte(logic [7:0] b);
        t_word_item it;
        it.b     = b;
        it.fixed = 1'b0;
        it.want  = '0;
        word_q.push_back(it);
    endtask

    // two digits, now and then one or both of them garbled
    task automatic push_pair(int v);
        logic [7:0] d1;
        logic [7:0] d2;
        d1 = 8'(clp_pkg::CH_0 + v / 10);
        d2 = 8'(clp_pkg::CH_0 + v % 10);
        if ($urandom_range(0, 15) == 0) d1 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) d2 = 8'($urandom_range(0, 255));
        push_byte(d1);
        push_byte(d2);
    endtask

    task automatic push_eol();
        push_byte($urandom_range(0, 1) ? clp_pkg::CH_CR : clp_pkg::CH_LF);
    endtask

    task automatic gen_line();
        int sel;
        int n;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            push_byte(clp_pkg::CH_T);
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 99);
                else v = $urandom_range(0, k == 0 ? 23 : 59);
                push_pair(v);
            end
            push_eol();
        end else if (sel < 40) begin
            push_byte(clp_pkg::CH_H);
            case ($urandom_range(0, 5))
                0: push_byte(8'($urandom_range(0, 255)));
                1: push_byte(8'($urandom_range(8'h32, 8'h39)));
                2, 3: push_byte(clp_pkg::CH_0);
                default: push_byte(clp_pkg::CH_1);
            endcase
            push_eol();
        end else if (sel < 58) begin
            push_byte(clp_pkg::CH_F);
            if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 99);
            else v = $urandom_range(1, 59);
            push_pair(v);
            push_eol();
        end else if (sel < 70) begin
            case ($urandom_range(0, 2))
                0: push_byte(clp_pkg::CH_T);
                1: push_byte(clp_pkg::CH_H);
                default: push_byte(clp_pkg::CH_F);
            endcase
            n = $urandom_range(0, 9);
            repeat (n) push_byte(8'($urandom_range(clp_pkg::CH_0, 8'h39)));
            push_eol();
        end else if (sel < 82) begin
            n = $urandom_range(1, 10);
            repeat (n) push_byte(8'($urandom));
            if ($urandom_range(0, 1)) push_eol();
        end else if (sel < 84) begin
            if ($urandom_range(0, 1)) begin
                push_byte(clp_pkg::CH_T);
                push_pair(12);
                push_pair(0);
                push_pair(0);
            end
            n = $urandom_range(50, 120);
            repeat (n) push_byte(8'($urandom_range(8'h41, 8'h7A)));
            push_eol();
        end else if (sel < 92) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 1)) push_eol();
                else push_byte(clp_pkg::CH_BANG);
            end
        end else begin
            // '!' inside a command is not stored
            push_byte(clp_pkg::CH_H);
            push_byte(clp_pkg::CH_BANG);
            push_byte($urandom_range(0, 1) ? clp_pkg::CH_1 : clp_pkg::CH_0);
            push_eol();
        end
    endtask

    always @(posedge i_clk) begin : mon
        clp_pkg::t_result w;
        cyc++;
        rx_took = 1'b0;
        if (i_rst_n) begin
            if (tx_if.valid && tx_if.ready) begin
                if (pending_words.size() == 0) begin
                    report($sformatf("word %0d arrived with nothing pending", got_cnt));
                end else begin
                    compare_word(tx_if.data, pending_words.pop_front(), got_cnt);
                end
                got_cnt++;
            end
            if (rx_if.valid && rx_if.ready) begin
                rx_took = 1'b1;
                w = predict_reply(rx_if.rx_byte);
                if (word_q[send_idx].fixed) w = word_q[send_idx].want;
                pending_words.push_back(w);
            end
        end
    end

    always @(negedge i_clk) begin : drive_rx
        logic       v;
        logic [7:0] b;
        if (rx_took) send_idx++;
        v = rx_if.valid && !rx_took;
        b = rx_if.rx_byte;
        if (!v && i_rst_n && send_idx < word_q.size()) begin
            if ((send_idx >= 500 && send_idx < 700) || $urandom_range(0, 99) >= 15) begin
                v = 1'b1;
                b = word_q[send_idx].b;
            end
        end
        rx_if.valid   <= v;
        rx_if.rx_byte <= b;
    end

    always @(negedge i_clk) begin : drive_tx
        logic r;
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else if (!hold_done && got_cnt >= 300) begin
            // long back-pressure so the input stalls
            hold_done = 1'b1;
            hold_left = 150;
            r = 1'b0;
        end else if (got_cnt >= 500 && got_cnt < 700) begin
            r = 1'b1;
        end else begin
            r = ($urandom_range(0, 99) >= 15);
        end
        tx_if.ready <= r;
    end

    initial begin
        wait (cyc >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        tx_if.ready   = 1'b0;
        ln_len        = 0;
        foreach (ln_head[k]) ln_head[k] = 8'h00;

        dir_tab = '{
            '{clp_pkg::CH_LF,   1'b1, want_of(clp_pkg::CH_LF, 1'b0, 1'b0)},
            '{clp_pkg::CH_CR,   1'b1, want_of(clp_pkg::CH_CR, 1'b0, 1'b0)},
            '{clp_pkg::CH_BANG, 1'b1, want_of(clp_pkg::CH_BANG, 1'b1, 1'b0)},
            '{clp_pkg::CH_T,    1'b0, '0},
            '{"2",              1'b0, '0},
            '{"3",              1'b0, '0},
            '{"5",              1'b0, '0},
            '{"9",              1'b0, '0},
            '{"5",              1'b0, '0},
            '{"9",              1'b0, '0},
            '{clp_pkg::CH_CR,   1'b0, '0},
            '{clp_pkg::CH_H,    1'b0, '0},
            '{clp_pkg::CH_1,    1'b0, '0},
            '{clp_pkg::CH_LF,   1'b0, '0},
            '{clp_pkg::CH_F,    1'b0, '0},
            '{"5",              1'b0, '0},
            '{"9",              1'b0, '0},
            '{clp_pkg::CH_CR,   1'b0, '0},
            '{clp_pkg::CH_F,    1'b0, '0},
            '{clp_pkg::CH_0,    1'b0, '0},
            '{clp_pkg::CH_0,    1'b0, '0},
            '{clp_pkg::CH_LF,   1'b1, want_of(clp_pkg::CH_LF, 1'b0, 1'b1)},
            '{8'h00,            1'b0, '0},
            '{8'hFF,            1'b0, '0},
            '{clp_pkg::CH_CR,   1'b1, want_of(clp_pkg::CH_CR, 1'b0, 1'b1)}
        };
        foreach (dir_tab[k]) word_q.push_back(dir_tab[k]);

        // valid time followed by enough bytes to run far past capacity
        push_byte(clp_pkg::CH_T);
        push_byte("1");
        push_byte("2");
        repeat (4) push_byte(clp_pkg::CH_0);
        repeat (140) push_byte(8'($urandom_range(8'h41, 8'h7A)));
        push_eol();
        while (word_q.size() < N_DIR + RAND_ITEMS) gen_line();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (send_idx < word_q.size() || pending_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_words.size() != 0) report("words still pending at end");

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== clock_command_line_parser.f =====
sv/clp_pkg.sv
sv/clp_if.sv
sv/clock_command_line_parser.sv
sv/clp_checker.sv
dv/tb.sv
